@@ src/text_console_cursor_scroll_macros.svh @@
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared concurrent-check shorthands for the console block.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define TCCS_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("tccs: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define TCCS_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("tccs: next-cycle check failed");

`endif

@@ src/tccs_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console package
// Operation codes, character codes and the command passed front to back.
// ----------------------------------------------------------------------------
package tccs_pkg;

    // Operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Character codes with special meaning
    localparam logic [7:0] CH_NULL  = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);

    // Classified command kinds
    typedef enum logic [2:0] {
        K_NOP,
        K_CHAR,
        K_BS,
        K_NL,
        K_CLEAR,
        K_READ,
        K_READ_OOR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  ch;
        logic [4:0]  row;
        logic [6:0]  col;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

@@ src/tccs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1900
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tccs_front.sv @@
// ----------------------------------------------------------------------------
// Text console front end
// Accepts commands and classifies them into the kinds the back end executes.
// ----------------------------------------------------------------------------
module tccs_front import tccs_pkg::*; #(
    parameter int ROWS = 25,
    parameter int COLS = 76
) (
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_code,
    input  logic [4:0] cell_row,
    input  logic [6:0] cell_col,
    output logic       push,
    output cmd_t       cmd
);

    logic in_range;

    // Range check for reads
    assign in_range = ({2'b00, cell_row} < 7'(ROWS)) && ({1'b0, cell_col} < 8'(COLS));

    // Take a transaction whenever the queue has room
    assign push = start && !busy;

    // Classify the operation
    always_comb
    begin
        cmd.ch   = char_code;
        cmd.row  = cell_row;
        cmd.col  = cell_col;
        cmd.kind = K_NOP;
        unique case (operation)
            OP_PUT:
            begin
                case (char_code)
                    CH_NULL: cmd.kind = K_NOP;
                    CH_BS:   cmd.kind = K_BS;
                    CH_NL:   cmd.kind = K_NL;
                    default: cmd.kind = K_CHAR;
                endcase
            end
            OP_CLEAR: cmd.kind = K_CLEAR;
            OP_READ:  cmd.kind = in_range ? K_READ : K_READ_OOR;
            default:  cmd.kind = K_NOP;
        endcase
    end

endmodule

@@ src/tccs_queue.sv @@
// ----------------------------------------------------------------------------
// Text console command queue
// Short FIFO of classified commands between front and back end.
// ----------------------------------------------------------------------------
module tccs_queue import tccs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PW:0]   count_reg, count_next;

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (Q_PW+1)'(Q_DEPTH));

endmodule

@@ src/tccs_back.sv @@
// ----------------------------------------------------------------------------
// Text console back end
// Executes commands against the screen store and owns the cursor. Rows live
// in a circular buffer: a scroll moves the base row and invalidates one row.
// ----------------------------------------------------------------------------
module tccs_back import tccs_pkg::*; #(
    parameter int ROWS = 25,
    parameter int COLS = 76
) (
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  cmd_t       head,
    output logic       pop,
    output logic       done,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_col,
    output logic       scrolled,
    output logic [7:0] read_char
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [RW-1:0]   cur_row_reg, cur_row_next;
    logic [CW-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]   base_reg, base_next;
    logic [ROWS-1:0] row_valid_reg, row_valid_next;
    logic [CW-1:0]   fill_col_reg, fill_col_next;
    cmd_t            cmd_reg, cmd_next;
    logic            done_reg, done_next;
    logic            scrolled_reg, scrolled_next;
    logic [7:0]      read_char_reg, read_char_next;

    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [7:0]      mem_wdata;
    logic [7:0]      mem_rdata;

    logic [RW-1:0]   cmd_row_l;
    logic [CW-1:0]   cmd_col_l;
    logic [RW-1:0]   cur_phys;
    logic [RW-1:0]   rd_phys;
    logic            bs_move;
    logic [CW-1:0]   wr_col;
    logic [7:0]      wr_data;
    logic [CW:0]     col_inc;
    logic            col_wrap;
    logic [RW:0]     row_inc;
    logic            row_over;
    logic [RW-1:0]   base_inc;
    logic            fill_last;

    // Map a screen row onto its row in the store
    function automatic logic [RW-1:0] to_phys(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] base);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, base};
        if (sum >= (RW+1)'(ROWS))
        begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    // Form a store address from row and column
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                                input logic [CW-1:0] col);
        return AW'(prow) * AW'(COLS) + AW'(col);
    endfunction

    tccs_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Cursor and row arithmetic
    assign cmd_row_l = RW'(cmd_reg.row);
    assign cmd_col_l = CW'(cmd_reg.col);
    assign cur_phys  = to_phys(cur_row_reg, base_reg);
    assign rd_phys   = to_phys(cmd_row_l, base_reg);
    assign bs_move   = (cmd_reg.kind == K_BS) && (cur_col_reg != '0);
    assign wr_col    = bs_move ? cur_col_reg - 1'b1 : cur_col_reg;
    assign wr_data   = bs_move ? CH_SPACE : cmd_reg.ch;
    assign col_inc   = {1'b0, cur_col_reg} + 1'b1;
    assign col_wrap  = (col_inc == (CW+1)'(COLS));
    assign row_inc   = {1'b0, cur_row_reg} + 1'b1;
    assign row_over  = (row_inc == (RW+1)'(ROWS));
    assign base_inc  = (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + 1'b1;
    assign fill_last = (fill_col_reg == CW'(COLS - 1));

    // Sequence one command at a time
    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        base_next      = base_reg;
        row_valid_next = row_valid_reg;
        fill_col_next  = fill_col_reg;
        cmd_next       = cmd_reg;
        done_next      = 1'b0;
        scrolled_next  = 1'b0;
        read_char_next = read_char_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = cell_addr(cur_phys, wr_col);
        mem_wdata      = wr_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Most commands finish here
                done_next      = 1'b1;
                read_char_next = '0;
                state_next     = S_IDLE;
                unique case (cmd_reg.kind) inside
                    K_CLEAR:
                    begin
                        row_valid_next = '0;
                    end
                    K_READ:
                    begin
                        if (row_valid_reg[rd_phys])
                        begin
                            done_next  = 1'b0;
                            mem_addr   = cell_addr(rd_phys, cmd_col_l);
                            state_next = S_READ;
                        end
                    end
                    K_NL:
                    begin
                        cur_col_next = '0;
                        if (row_over)
                        begin
                            cur_row_next              = RW'(ROWS - 1);
                            base_next                 = base_inc;
                            row_valid_next[base_reg]  = 1'b0;
                            scrolled_next             = 1'b1;
                        end
                        else
                        begin
                            cur_row_next = row_inc[RW-1:0];
                        end
                    end
                    K_CHAR, K_BS:
                    begin
                        if (!row_valid_reg[cur_phys])
                        begin
                            // Blank the row before its first write
                            done_next     = 1'b0;
                            fill_col_next = '0;
                            state_next    = S_FILL;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            if (bs_move)
                            begin
                                cur_col_next = wr_col;
                            end
                            else if (col_wrap)
                            begin
                                cur_col_next = '0;
                                if (row_over)
                                begin
                                    cur_row_next             = RW'(ROWS - 1);
                                    base_next                = base_inc;
                                    row_valid_next[base_reg] = 1'b0;
                                    scrolled_next            = 1'b1;
                                end
                                else
                                begin
                                    cur_row_next = row_inc[RW-1:0];
                                end
                            end
                            else
                            begin
                                cur_col_next = col_inc[CW-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        // Null put, unused operation, read out of range
                    end
                endcase
            end

            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_addr  = cell_addr(cur_phys, fill_col_reg);
                mem_wdata = '0;
                if (fill_last)
                begin
                    row_valid_next[cur_phys] = 1'b1;
                    state_next               = S_EXEC;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end

            S_READ:
            begin
                read_char_next = mem_rdata;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold command payload
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            base_reg      <= '0;
            row_valid_reg <= '0;
            fill_col_reg  <= '0;
            done_reg      <= 1'b0;
            scrolled_reg  <= 1'b0;
            read_char_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            base_reg      <= base_next;
            row_valid_reg <= row_valid_next;
            fill_col_reg  <= fill_col_next;
            done_reg      <= done_next;
            scrolled_reg  <= scrolled_next;
            read_char_reg <= read_char_next;
        end
    end

    assign done       = done_reg;
    assign cursor_row = 5'(cur_row_reg);
    assign cursor_col = 7'(cur_col_reg);
    assign scrolled   = scrolled_reg;
    assign read_char  = read_char_reg;

endmodule

@@ src/text_console_cursor_scroll.sv @@
// ----------------------------------------------------------------------------
// Text console with cursor and scroll
// Character-cell screen store with put, clear and read commands.
//
//   Channel   Handshake      Payload
//   command   start / busy   operation, char_code, cell_row, cell_col
//   result    done strobe    cursor_row, cursor_col, scrolled, read_char
//
// A command runs through the idle and execute states; a read of a written row adds
// the read state. The first write into a blank row first fills that row with zeros
// through the single store port; scroll and clear sweep nothing in the store.
// Reset clears the cursor and all row-valid bits; no sweep follows reset.
// busy rises when the two-entry command queue is full; done cannot be stalled.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_macros.svh"

module text_console_cursor_scroll import tccs_pkg::*; #(
    parameter int ROWS = 25,
    parameter int COLS = 76
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_code,
    input  logic [4:0] cell_row,
    input  logic [6:0] cell_col,
    output logic       done,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_col,
    output logic       scrolled,
    output logic [7:0] read_char
);

    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;

    assign busy = q_status.full;

    tccs_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .char_code (char_code),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .push      (push),
        .cmd       (push_cmd)
    );

    tccs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    tccs_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .read_char  (read_char)
    );

    // Checks
    `TCCS_ASSERT_IMPL(a_cursor_in_range, clk, rst_n, done, ({1'b0, cursor_col} < 8'(COLS)))
    `TCCS_ASSERT_IMPL(a_scroll_home, clk, rst_n, done && scrolled, (cursor_col == '0) && (cursor_row == 5'(ROWS - 1)))
    `TCCS_ASSERT_IMPL(a_scroll_strobe, clk, rst_n, scrolled, done)
    `TCCS_ASSERT_NEXT(a_push_lands, clk, rst_n, start && !busy, !q_status.empty)

endmodule

@@ bench/text_console_cursor_scroll_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console checker
// Watches the command and result channels of the console. It keeps its own
// screen store and cursor, works out the status each accepted command should
// return, and compares every done strobe field by field with the oldest one.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_checker import tccs_pkg::*; #(
    parameter int ROWS = 25,
    parameter int COLS = 76
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] operation,
    input  logic [7:0] char_code,
    input  logic [4:0] cell_row,
    input  logic [6:0] cell_col,
    input  logic       done,
    input  logic [4:0] cursor_row,
    input  logic [6:0] cursor_col,
    input  logic       scrolled,
    input  logic [7:0] read_char,
    output int         fail_count,
    output int         pending
);

    typedef struct {
        logic [4:0] row;
        logic [6:0] col;
        logic       scrolled;
        logic [7:0] rd_char;
    } console_status_t;

    logic [7:0]      screen [ROWS*COLS];
    int              cur_row;
    int              cur_col;
    console_status_t status_due [$];

    // Move every row up by one, blank the bottom row, park the cursor
    task automatic scroll_screen();
        for (int i = 0; i < (ROWS - 1) * COLS; i++)
        begin
            screen[i] = screen[i + COLS];
        end
        for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
        begin
            screen[i] = '0;
        end
        cur_row = ROWS - 1;
        cur_col = 0;
    endtask

    // Apply one command to the shadow console and queue its status
    task automatic predict_console(input logic [1:0] op, input logic [7:0] ch,
                                   input logic [4:0] rrow, input logic [6:0] rcol);
        console_status_t st;
        st.scrolled = 1'b0;
        st.rd_char  = '0;
        if (op == OP_PUT && ch != CH_NULL)
        begin
            if (ch == CH_BS && cur_col > 0)
            begin
                cur_col--;
                screen[cur_row * COLS + cur_col] = CH_SPACE;
            end
            else if (ch == CH_NL)
            begin
                cur_row++;
                cur_col = 0;
            end
            else
            begin
                // backspace at column zero lands here and is stored as a byte
                screen[cur_row * COLS + cur_col] = ch;
                cur_col++;
                if (cur_col >= COLS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            if (cur_row >= ROWS)
            begin
                scroll_screen();
                st.scrolled = 1'b1;
            end
        end
        else if (op == OP_CLEAR)
        begin
            foreach (screen[i])
                screen[i] = '0;
        end
        else if (op == OP_READ)
        begin
            if (rrow < ROWS && rcol < COLS)
                st.rd_char = screen[rrow * COLS + rcol];
        end
        st.row = cur_row[4:0];
        st.col = cur_col[6:0];
        status_due.push_back(st);
    endtask

    // Compare one result transaction with the oldest expected status
    task automatic check_status();
        console_status_t st;
        if (status_due.size() == 0)
        begin
            $error("done strobe with no command outstanding");
            fail_count++;
        end
        else
        begin
            st = status_due.pop_front();
            if (cursor_row !== st.row)
            begin
                $error("cursor_row: expected %0d, actual %0d", st.row, cursor_row);
                fail_count++;
            end
            if (cursor_col !== st.col)
            begin
                $error("cursor_col: expected %0d, actual %0d", st.col, cursor_col);
                fail_count++;
            end
            if (scrolled !== st.scrolled)
            begin
                $error("scrolled: expected %0d, actual %0d", st.scrolled, scrolled);
                fail_count++;
            end
            if (read_char !== st.rd_char)
            begin
                $error("read_char: expected %0d, actual %0d", st.rd_char, read_char);
                fail_count++;
            end
        end
    endtask

    // Retire results first, then record the newly accepted command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (screen[i])
                screen[i] = '0;
            cur_row    = 0;
            cur_col    = 0;
            status_due.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (done)
                check_status();
            if (start && !busy)
                predict_console(operation, char_code, cell_row, cell_col);
            pending = status_due.size();
        end
    end

endmodule

@@ bench/tb_text_console_cursor_scroll.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console testbench
// Drives put, clear, read and unused commands into the console: a directed
// opening over the special characters and edge cells, then random text with
// line breaks, long wrapping runs, backspaces and reads. Results are checked
// by the checker module; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll import tccs_pkg::*;;

    localparam int         ROWS         = 25;
    localparam int         COLS         = 76;
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         N_RANDOM     = 1400;
    localparam int         QUIET_TAIL   = 150;
    localparam int         DRAIN_CYCLES = COLS + 40;
    localparam int         IDLE_LIMIT   = 5000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
    logic       done;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       scrolled;
    logic [7:0] read_char;
    int         fail_count;
    int         pending;
    int         quiet_cycles;

    text_console_cursor_scroll #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .char_code  (char_code),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .done       (done),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .read_char  (read_char)
    );

    text_console_cursor_scroll_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .char_code  (char_code),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .done       (done),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .read_char  (read_char),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one command and hold it until a transaction takes it
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch,
                            input logic [4:0] rrow, input logic [6:0] rcol);
        @(negedge clk);
        start     <= 1'b1;
        operation <= op;
        char_code <= ch;
        cell_row  <= rrow;
        cell_col  <= rcol;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    // Drop start for a number of cycles
    task automatic idle_gap(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Put with random filler on the unused read fields
    task automatic send_put(input logic [7:0] ch);
        send_cmd(OP_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    // Abort on a long stretch with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         pick;
        int         long_run;
        int         segment_left;
        bit         idle_on;

        start        = 1'b0;
        operation    = OP_PUT;
        char_code    = CH_NULL;
        cell_row     = '0;
        cell_col     = '0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: special characters, edge cells, every operation
        send_cmd(OP_READ, 8'hFF, 5'd0, 7'd0);
        send_put(8'h41);
        send_put(CH_NULL);
        send_put(8'hFF);
        send_put(CH_BS);
        send_cmd(OP_READ, 8'h00, 5'd0, 7'd1);
        send_put(CH_NL);
        send_put(CH_BS);
        send_cmd(OP_READ, 8'h00, 5'd1, 7'd0);
        send_put(8'h80);
        send_put(8'h55);
        send_put(8'hAA);
        send_cmd(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1));
        send_cmd(OP_READ, 8'h00, 5'(ROWS), 7'd0);
        send_cmd(OP_READ, 8'h00, 5'd0, 7'(COLS));
        send_cmd(OP_READ, 8'hFF, 5'h1F, 7'h7F);
        send_cmd(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
        send_cmd(OP_CLEAR, 8'h41, 5'd1, 7'd1);
        send_cmd(OP_READ, 8'h00, 5'd1, 7'd3);
        send_put(8'h01);
        send_put(8'h7F);
        send_cmd(OP_READ, 8'h00, 5'd1, 7'd1);

        // Random text: lines, long wrapping runs, edits, reads, rare clears
        long_run     = 0;
        segment_left = 0;
        idle_on      = 1'b0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            pick = $urandom_range(0, 99);
            if (long_run > 0)
            begin
                long_run--;
                send_put(8'($urandom_range(32, 126)));
            end
            else if (pick < 45)
                send_put(8'($urandom_range(32, 126)));
            else if (pick < 55)
                send_put(8'($urandom));
            else if (pick < 65)
                send_put(CH_NL);
            else if (pick < 71)
                send_put(CH_BS);
            else if (pick < 73)
                send_put(CH_NULL);
            else if (pick < 75)
            begin
                // run past the line end to force wraps and scrolls
                long_run = $urandom_range(COLS - 16, 2 * COLS + 8);
                send_put(8'($urandom_range(32, 126)));
            end
            else if (pick < 88)
                send_cmd(OP_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                         7'($urandom_range(0, COLS - 1)));
            else if (pick < 94)
                send_cmd(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
            else if (pick < 97)
                send_cmd(OP_READ, 8'($urandom), 5'(ROWS - 1 - $urandom_range(0, 1)),
                         7'(($urandom_range(0, 1) == 0) ? 0 : COLS - 1));
            else if (pick < 98)
                send_cmd(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            else
                send_cmd(OP_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));

            // Alternate stretches with and without sender idling
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(20, 80);
                idle_on      = $urandom_range(0, 1);
            end
            segment_left--;
            if (n < N_RANDOM - QUIET_TAIL && idle_on && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 15));
        end

        // Drain outstanding results, then leave room for stray strobes
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ text_console_cursor_scroll.f @@
+incdir+src
src/tccs_pkg.sv
src/tccs_ram.sv
src/tccs_front.sv
src/tccs_queue.sv
src/tccs_back.sv
src/text_console_cursor_scroll.sv
bench/text_console_cursor_scroll_checker.sv
bench/tb_text_console_cursor_scroll.sv
